[rtl/hfbd_pkg.sv]
// shared types, constants and tables of the heatmap face box decoder
package hfbd_pkg;

    localparam int NUM_KEYPOINTS = 5;
    localparam int MAP_STRIDE    = 4;
    localparam int CNT_W         = 3;
    localparam int IN_DATA_W     = 136;
    localparam int OUT_DATA_W    = 96;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 16;

    localparam logic [16:0] LOG2E_Q15 = 17'd47274;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SCORE_THRESHOLD = 3'd0,
        REG_FRAME_WIDTH     = 3'd1,
        REG_FRAME_HEIGHT    = 3'd2,
        REG_SCALE_BACK_X    = 3'd3,
        REG_SCALE_BACK_Y    = 3'd4
    } t_cfg_reg;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOG,
        OP_EXP,
        OP_SIZE,
        OP_EDGE,
        OP_SPAN,
        OP_BOX,
        OP_KP_MUL,
        OP_KP_PROD,
        OP_KP_OUT
    } t_dp_op;

    typedef struct packed {
        t_dp_op           op;
        logic             capture;
        logic [CNT_W-1:0] point_index;
        logic             last;
    } t_dp_cmd;

    typedef struct packed {
        logic cmd;
        logic pass;
        logic out_busy;
    } t_dp_sts;

    // 2^(i/16) in Q2.16
    function automatic logic [17:0] pow2_q16(input logic [4:0] i);
        logic [17:0] v;
        case (i)
            5'd0:    v = 18'd65536;
            5'd1:    v = 18'd68438;
            5'd2:    v = 18'd71468;
            5'd3:    v = 18'd74632;
            5'd4:    v = 18'd77936;
            5'd5:    v = 18'd81386;
            5'd6:    v = 18'd84990;
            5'd7:    v = 18'd88752;
            5'd8:    v = 18'd92682;
            5'd9:    v = 18'd96785;
            5'd10:   v = 18'd101070;
            5'd11:   v = 18'd105545;
            5'd12:   v = 18'd110218;
            5'd13:   v = 18'd115098;
            5'd14:   v = 18'd120194;
            5'd15:   v = 18'd125515;
            default: v = 18'd131072;
        endcase
        return v;
    endfunction

endpackage

[rtl/hfbd_ctrl.sv]
// controller state machine of the heatmap face box decoder
module hfbd_ctrl import hfbd_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [9:0] {
        ST_IDLE    = 10'b0000000001,
        ST_LOG     = 10'b0000000010,
        ST_EXP     = 10'b0000000100,
        ST_SIZE    = 10'b0000001000,
        ST_EDGE    = 10'b0000010000,
        ST_SPAN    = 10'b0000100000,
        ST_BOX     = 10'b0001000000,
        ST_KP_MUL  = 10'b0010000000,
        ST_KP_PROD = 10'b0100000000,
        ST_KP_OUT  = 10'b1000000000
    } t_state;

    t_state           r_state, n_state;
    logic             r_face_active, n_face_active;
    logic [CNT_W-1:0] r_count, n_count;
    logic             accept;
    logic             at_last;

    assign o_in_ready = (r_state == ST_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign at_last    = (r_count == CNT_W'(NUM_KEYPOINTS - 1));

    always_comb begin
        n_state             = r_state;
        n_face_active       = r_face_active;
        n_count             = r_count;
        o_cmd.op            = OP_NONE;
        o_cmd.capture       = accept;
        o_cmd.point_index   = r_count;
        o_cmd.last          = at_last;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (!i_sts.cmd) begin
                        n_count       = '0;
                        n_face_active = i_sts.pass;
                        if (i_sts.pass) begin
                            n_state = ST_LOG;
                        end
                    end else if (r_face_active) begin
                        n_state = ST_KP_MUL;
                    end
                end
            end
            ST_LOG: begin
                o_cmd.op = OP_LOG;
                n_state  = ST_EXP;
            end
            ST_EXP: begin
                o_cmd.op = OP_EXP;
                n_state  = ST_SIZE;
            end
            ST_SIZE: begin
                o_cmd.op = OP_SIZE;
                n_state  = ST_EDGE;
            end
            ST_EDGE: begin
                o_cmd.op = OP_EDGE;
                n_state  = ST_SPAN;
            end
            ST_SPAN: begin
                o_cmd.op = OP_SPAN;
                n_state  = ST_BOX;
            end
            ST_BOX: begin
                if (!i_sts.out_busy) begin
                    o_cmd.op = OP_BOX;
                    n_state  = ST_IDLE;
                end
            end
            ST_KP_MUL: begin
                o_cmd.op = OP_KP_MUL;
                n_state  = ST_KP_PROD;
            end
            ST_KP_PROD: begin
                o_cmd.op = OP_KP_PROD;
                n_state  = ST_KP_OUT;
            end
            ST_KP_OUT: begin
                if (!i_sts.out_busy) begin
                    o_cmd.op = OP_KP_OUT;
                    n_state  = ST_IDLE;
                    if (at_last) begin
                        n_face_active = 1'b0;
                        n_count       = '0;
                    end else begin
                        n_count = r_count + CNT_W'(1);
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_face_active <= 1'b0;
            r_count       <= '0;
        end else begin
            r_state       <= n_state;
            r_face_active <= n_face_active;
            r_count       <= n_count;
        end
    end

endmodule

[rtl/hfbd_dp.sv]
// datapath of the heatmap face box decoder: registers, lanes for y and x, result register
module hfbd_dp import hfbd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    output t_dp_sts               o_sts,
    input  logic [IN_DATA_W-1:0]  i_in_data,
    input  logic                  i_in_cmd,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [OUT_DATA_W-1:0] o_out_data,
    output logic                  o_out_kind,
    output logic                  o_out_last
);

    // lane 0 is vertical, lane 1 horizontal
    logic [15:0]        r_thr;
    logic [12:0]        r_frame [2];
    logic [14:0]        r_scale [2];

    logic [9:0]         r_idx [2];
    logic signed [15:0] r_off [2];
    logic signed [15:0] r_log [2];
    logic signed [15:0] r_lm  [2];
    logic [15:0]        r_score_in;
    logic [15:0]        r_held_score;

    logic signed [32:0] r_t     [2];
    logic [17:0]        r_m     [2];
    logic signed [5:0]  r_sh    [2];
    logic [23:0]        r_size  [2];
    logic [16:0]        r_edge  [2];
    logic [16:0]        r_span  [2];
    logic signed [31:0] r_lmsc  [2];
    logic [31:0]        r_esc   [2];
    logic signed [56:0] r_kprod [2];

    logic               r_out_valid;
    logic               r_kind;
    logic               r_last;
    logic [18:0]        r_pos [2];
    logic [16:0]        r_box [2];
    logic [15:0]        r_oscore;
    logic [CNT_W-1:0]   r_pidx;

    logic signed [32:0] n_t     [2];
    logic [17:0]        n_m     [2];
    logic signed [5:0]  n_sh    [2];
    logic [23:0]        n_size  [2];
    logic [16:0]        n_edge  [2];
    logic [16:0]        n_span  [2];
    logic [18:0]        n_pos   [2];
    logic [16:0]        n_box   [2];
    logic signed [31:0] n_lmsc  [2];
    logic [31:0]        n_esc   [2];
    logic signed [56:0] n_kprod [2];
    logic [18:0]        n_kpos  [2];

    assign o_sts.cmd      = i_in_cmd;
    assign o_sts.pass     = (i_in_data[35:20] >= r_thr);
    assign o_sts.out_busy = r_out_valid && !i_out_ready;

    always_comb begin
        logic [3:0]         tab_i;
        logic [11:0]        frac;
        logic [17:0]        base;
        logic [12:0]        diff;
        logic [25:0]        interp;
        logic [4:0]         shr;
        logic [24:0]        wide;
        logic signed [31:0] cen;
        logic signed [31:0] corner;
        logic [16:0]        lim;
        logic [24:0]        far;
        logic [32:0]        pe;
        logic [32:0]        be;
        logic signed [57:0] ksum;
        logic signed [31:0] kq;
        for (int i = 0; i < 2; i++) begin
            n_t[i] = 33'(r_log[i]) * $signed(33'(LOG2E_Q15));

            tab_i   = r_t[i][26:23];
            frac    = r_t[i][22:11];
            base    = pow2_q16({1'b0, tab_i});
            diff    = 13'(pow2_q16({1'b0, tab_i} + 5'd1) - base);
            interp  = 26'(diff) * 26'(frac) + 26'd2048;
            n_m[i]  = base + 18'(interp >> 12);
            n_sh[i] = $signed(r_t[i][32:27]) - 6'sd10;

            shr = 5'(-r_sh[i]);
            if (!r_sh[i][5]) begin
                wide = 25'(r_m[i]) << r_sh[i][0];
            end else begin
                wide = (25'(r_m[i]) + (25'd1 << (shr - 5'd1))) >> shr;
            end
            n_size[i] = wide[24] ? 24'hFFFFFF : wide[23:0];

            lim    = {r_frame[i], 4'b0000};
            cen    = $signed({10'b0, r_idx[i], 12'b0}) + 32'(r_off[i]) + 32'sd2048;
            corner = ((cen * $signed(32'(MAP_STRIDE)) + 32'sd128) >>> 8)
                     - $signed({9'b0, r_size[i][23:1]});
            if (corner < 0) begin
                n_edge[i] = '0;
            end else if (corner > $signed({15'b0, lim})) begin
                n_edge[i] = lim;
            end else begin
                n_edge[i] = corner[16:0];
            end

            far = 25'(r_edge[i]) + 25'(r_size[i]);
            if (far > 25'(lim)) begin
                far = 25'(lim);
            end
            n_span[i] = 17'(far - 25'(r_edge[i]));

            pe       = 33'(r_edge[i]) * 33'(r_scale[i]) + 33'd8192;
            n_pos[i] = pe[32] ? 19'h3FFFF : pe[32:14];
            be       = 33'(r_span[i]) * 33'(r_scale[i]) + 33'd8192;
            n_box[i] = (be[32:31] != 2'b00) ? 17'h1FFFF : be[30:14];

            n_lmsc[i]  = 32'(r_lm[i]) * $signed({17'b0, r_scale[i]});
            n_esc[i]   = 32'(r_edge[i]) * 32'(r_scale[i]);
            n_kprod[i] = $signed({33'b0, r_size[i]}) * 57'(r_lmsc[i]);

            ksum = 58'(r_kprod[i]) + $signed({14'b0, r_esc[i], 12'b0})
                   + 58'sd33554432;
            kq   = 32'(ksum >>> 26);
            if (kq > 32'sd262143) begin
                n_kpos[i] = 19'h3FFFF;
            end else if (kq < -32'sd262144) begin
                n_kpos[i] = 19'h40000;
            end else begin
                n_kpos[i] = kq[18:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr      <= 16'd32768;
            r_frame[0] <= 13'd480;
            r_frame[1] <= 13'd640;
            r_scale[0] <= 15'd16384;
            r_scale[1] <= 15'd16384;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_SCORE_THRESHOLD: r_thr      <= i_cfg_data;
                REG_FRAME_WIDTH:     r_frame[1] <= i_cfg_data[12:0];
                REG_FRAME_HEIGHT:    r_frame[0] <= i_cfg_data[12:0];
                REG_SCALE_BACK_X:    r_scale[1] <= i_cfg_data[14:0];
                REG_SCALE_BACK_Y:    r_scale[0] <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.op == OP_BOX || i_cmd.op == OP_KP_OUT) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_idx[0]   <= i_in_data[9:0];
            r_idx[1]   <= i_in_data[19:10];
            r_score_in <= i_in_data[35:20];
            r_log[0]   <= i_in_data[51:36];
            r_log[1]   <= i_in_data[67:52];
            r_off[0]   <= i_in_data[83:68];
            r_off[1]   <= i_in_data[99:84];
            r_lm[0]    <= i_in_data[115:100];
            r_lm[1]    <= i_in_data[131:116];
        end
        for (int i = 0; i < 2; i++) begin
            case (i_cmd.op)
                OP_LOG:     r_t[i]     <= n_t[i];
                OP_EXP: begin
                    r_m[i]  <= n_m[i];
                    r_sh[i] <= n_sh[i];
                end
                OP_SIZE:    r_size[i]  <= n_size[i];
                OP_EDGE:    r_edge[i]  <= n_edge[i];
                OP_SPAN:    r_span[i]  <= n_span[i];
                OP_BOX: begin
                    r_pos[i] <= n_pos[i];
                    r_box[i] <= n_box[i];
                end
                OP_KP_MUL: begin
                    r_lmsc[i] <= n_lmsc[i];
                    r_esc[i]  <= n_esc[i];
                end
                OP_KP_PROD: r_kprod[i] <= n_kprod[i];
                OP_KP_OUT: begin
                    r_pos[i] <= n_kpos[i];
                    r_box[i] <= '0;
                end
                default: ;
            endcase
        end
        case (i_cmd.op)
            OP_BOX: begin
                r_held_score <= r_score_in;
                r_oscore     <= r_score_in;
                r_kind       <= 1'b0;
                r_last       <= 1'b0;
                r_pidx       <= '0;
            end
            OP_KP_OUT: begin
                r_oscore <= r_held_score;
                r_kind   <= 1'b1;
                r_last   <= i_cmd.last;
                r_pidx   <= i_cmd.point_index;
            end
            default: ;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_kind  = r_kind;
    assign o_out_last  = r_last;
    assign o_out_data  = {5'b0, r_pidx, r_oscore, r_box[0], r_box[1], r_pos[0], r_pos[1]};

endmodule

[rtl/heatmap_face_box_decoder.sv]
// top level of the heatmap face box decoder
// usage: heatmap cell items (tuser = 0) and landmark items (tuser = 1) enter on the
// s_axis channel; a cell whose score reaches the threshold yields one face box item,
// and each of the five landmark items after it yields one keypoint item, the fifth
// with tlast set. results leave on the m_axis channel (tuser 0 box, 1 keypoint).
// registers are written on the cfg channel, which is always ready; the user must
// write them only while idle, the block itself does not enforce it. a passing cell
// runs through a six-step sequence (log multiply, exp table interpolation, size
// shift, corner clamp, far corner, scale back) that ends in its box item; a landmark
// runs three steps (two multiplies, then a rounded sum with clamp). failing cells
// and landmarks with no face give nothing. input is refused while the sequencer
// steps the one shared pair of x/y lanes, so one item is worked on at a time.
// the result sits in an output register; a stalled receiver holds the sequence
// in its last step until that register frees, input is refused meanwhile.
// reset restores the register defaults and drops any face in progress.
module heatmap_face_box_decoder import hfbd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // row, col, score, log_size_y, log_size_x, offset_y, offset_x, landmark_y, landmark_x
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // cmd
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // pos_x, pos_y, box_width, box_height, face_score, point_index
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // kind
    output logic                  m_axis_tuser,
    output logic                  m_axis_tlast,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    assign o_cfg_ready = 1'b1;

    hfbd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    hfbd_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_data   (s_axis_tdata),
        .i_in_cmd    (s_axis_tuser),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata),
        .o_out_kind  (m_axis_tuser),
        .o_out_last  (m_axis_tlast)
    );

endmodule

[tb/hfbd_checker.sv]
// checker for the heatmap face box decoder: predicts box and keypoint items and compares them
module hfbd_checker import hfbd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  logic                  s_axis_tuser,
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                  m_axis_tuser,
    input  logic                  m_axis_tlast,
    input  logic                  i_cfg_valid,
    input  logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_errors,
    output int                    o_pending,
    output int                    o_checked,
    output int                    o_faces
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint EXP_TAB [17] = '{65536, 68438, 71468, 74632, 77936, 81386, 84990,
        88752, 92682, 96785, 101070, 105545, 110218, 115098, 120194, 125515, 131072};
    localparam longint POS_HI = 262143;
    localparam longint POS_LO = -262144;
    localparam longint BOX_HI = 131071;

    typedef struct packed {
        logic        kind;
        logic [18:0] pos_x;
        logic [18:0] pos_y;
        logic [16:0] box_w;
        logic [16:0] box_h;
        logic [15:0] face_score;
        logic [2:0]  point_index;
        logic        last;
    } t_face_item;

    t_face_item  face_items_due[$];
    logic [15:0] thr;
    logic [12:0] frame_w, frame_h;
    logic [14:0] scale_x, scale_y;
    logic        face_on;
    logic [23:0] size_y, size_x;
    longint      top_edge, left_edge;
    int          kp_count;
    logic [15:0] held_score;

    function automatic longint rnd_shift(input longint v, input int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic logic [18:0] sat_pos(input longint v);
        longint c;
        c = v > POS_HI ? POS_HI : (v < POS_LO ? POS_LO : v);
        return c[18:0];
    endfunction

    function automatic longint scale_up(input longint v, input logic [14:0] sc);
        return (v * longint'(sc) + 8192) >> 14;
    endfunction

    function automatic logic [23:0] exp_size(input logic [15:0] raw);
        longint t, m, v, r;
        int     n, sh, idx;
        logic [15:0] f;
        t = longint'($signed(raw)) * 47274 + (longint'(16) << 27);
        n = int'(t >>> 27) - 16;
        f = t[26:11];
        idx = int'(f[15:12]);
        r = longint'(f[11:0]);
        m = EXP_TAB[idx] + (((EXP_TAB[idx+1] - EXP_TAB[idx]) * r + 2048) >> 12);
        sh = n - 10;
        if (sh >= 0) v = m << sh;
        else v = (m + (longint'(1) << (-sh - 1))) >> (-sh);
        return v > 64'hFFFFFF ? 24'hFFFFFF : v[23:0];
    endfunction

    function automatic longint corner(input logic [9:0] idx, input logic [15:0] off,
                                      input logic [23:0] sz, input logic [12:0] frame);
        longint c, e, lim;
        c = (longint'(idx) << 12) + longint'($signed(off)) + 2048;
        e = rnd_shift(c * MAP_STRIDE, 8) - longint'(sz >> 1);
        lim = longint'(frame) * 16;
        if (e < 0) e = 0;
        if (e > lim) e = lim;
        return e;
    endfunction

    function automatic logic [18:0] key_pos(input logic [23:0] sz, input logic [15:0] lm,
                                            input longint edge_q4, input logic [14:0] sc);
        longint v;
        v = longint'(sz) * longint'($signed(lm)) + (edge_q4 << 12);
        return sat_pos(rnd_shift(v * longint'(sc), 26));
    endfunction

    task automatic decode_item(input logic cmd, input logic [IN_DATA_W-1:0] d);
        t_face_item e;
        longint ymax, xmax, fy, fx, bw, bh;
        e = '0;
        if (!cmd) begin
            kp_count = 0;
            if (d[35:20] < thr) begin
                face_on = 1'b0;
                return;
            end
            size_y = exp_size(d[51:36]);
            size_x = exp_size(d[67:52]);
            top_edge = corner(d[9:0], d[83:68], size_y, frame_h);
            left_edge = corner(d[19:10], d[99:84], size_x, frame_w);
            fy = longint'(frame_h) * 16;
            fx = longint'(frame_w) * 16;
            ymax = top_edge + size_y > fy ? fy : top_edge + size_y;
            xmax = left_edge + size_x > fx ? fx : left_edge + size_x;
            bw = scale_up(xmax - left_edge, scale_x);
            bh = scale_up(ymax - top_edge, scale_y);
            held_score = d[35:20];
            face_on = 1'b1;
            e.pos_x = sat_pos(scale_up(left_edge, scale_x));
            e.pos_y = sat_pos(scale_up(top_edge, scale_y));
            e.box_w = bw > BOX_HI ? BOX_HI[16:0] : bw[16:0];
            e.box_h = bh > BOX_HI ? BOX_HI[16:0] : bh[16:0];
            e.face_score = held_score;
            o_faces++;
            face_items_due.insert(face_items_due.size(), e);
            return;
        end
        if (!face_on) return;
        e.kind = 1'b1;
        e.pos_x = key_pos(size_x, d[131:116], left_edge, scale_x);
        e.pos_y = key_pos(size_y, d[115:100], top_edge, scale_y);
        e.face_score = held_score;
        e.point_index = kp_count[2:0];
        if (kp_count + 1 >= NUM_KEYPOINTS) begin
            e.last = 1'b1;
            face_on = 1'b0;
            kp_count = 0;
        end else begin
            kp_count++;
        end
        face_items_due.insert(face_items_due.size(), e);
    endtask

    task automatic compare_item();
        t_face_item e;
        if (face_items_due.size() == 0) begin
            $error("result item with nothing expected");
            o_errors++;
            return;
        end
        e = face_items_due.pop_front();
        o_checked++;
        if (m_axis_tuser !== e.kind) begin
            $error("kind exp %0d got %0d", e.kind, m_axis_tuser); o_errors++;
        end
        if (m_axis_tdata[18:0] !== e.pos_x) begin
            $error("pos_x exp %0d got %0d", $signed(e.pos_x), $signed(m_axis_tdata[18:0]));
            o_errors++;
        end
        if (m_axis_tdata[37:19] !== e.pos_y) begin
            $error("pos_y exp %0d got %0d", $signed(e.pos_y), $signed(m_axis_tdata[37:19]));
            o_errors++;
        end
        if (m_axis_tdata[54:38] !== e.box_w) begin
            $error("box_width exp %0d got %0d", e.box_w, m_axis_tdata[54:38]); o_errors++;
        end
        if (m_axis_tdata[71:55] !== e.box_h) begin
            $error("box_height exp %0d got %0d", e.box_h, m_axis_tdata[71:55]); o_errors++;
        end
        if (m_axis_tdata[87:72] !== e.face_score) begin
            $error("face_score exp %0d got %0d", e.face_score, m_axis_tdata[87:72]);
            o_errors++;
        end
        if (m_axis_tdata[90:88] !== e.point_index) begin
            $error("point_index exp %0d got %0d", e.point_index, m_axis_tdata[90:88]);
            o_errors++;
        end
        if (m_axis_tlast !== e.last) begin
            $error("last exp %0d got %0d", e.last, m_axis_tlast); o_errors++;
        end
    endtask

    initial begin
        o_errors = 0;
        o_checked = 0;
        o_faces = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            thr = 16'd32768;
            frame_w = 13'd640;
            frame_h = 13'd480;
            scale_x = 15'd16384;
            scale_y = 15'd16384;
            face_on = 1'b0;
            size_y = '0;
            size_x = '0;
            top_edge = 0;
            left_edge = 0;
            kp_count = 0;
            held_score = '0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) compare_item();
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_SCORE_THRESHOLD: thr = i_cfg_data;
                    REG_FRAME_WIDTH:     frame_w = i_cfg_data[12:0];
                    REG_FRAME_HEIGHT:    frame_h = i_cfg_data[12:0];
                    REG_SCALE_BACK_X:    scale_x = i_cfg_data[14:0];
                    REG_SCALE_BACK_Y:    scale_y = i_cfg_data[14:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) decode_item(s_axis_tuser, s_axis_tdata);
        end
        o_pending = face_items_due.size();
    end

endmodule

[tb/tb_heatmap_face_box_decoder.sv]
// testbench top of the heatmap face box decoder: stimulus, register setup and verdict
module tb_heatmap_face_box_decoder;
    import hfbd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 600000;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES = 12;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;
    localparam logic CMD_CELL = 1'b0;
    localparam logic CMD_MARK = 1'b1;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tuser;
    logic                  m_axis_tlast;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    int          errors, pending, checked, faces;
    int          cycles;
    int          items_sent;
    bit          no_idle;
    bit          hold_req;
    logic [15:0] cur_thr;

    heatmap_face_box_decoder dut (.*);

    hfbd_checker checker_i (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
        .i_cfg_valid, .o_cfg_ready, .i_cfg_index, .i_cfg_data,
        .o_errors(errors), .o_pending(pending), .o_checked(checked), .o_faces(faces)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    function automatic int draw_gap();
        return no_idle ? 0 : $urandom_range(0, 18);
    endfunction

    function automatic logic [IN_DATA_W-1:0] pack_item(
        input logic [9:0] row, input logic [9:0] col, input logic [15:0] score,
        input logic [15:0] ly, input logic [15:0] lx, input logic [15:0] oy,
        input logic [15:0] ox, input logic [15:0] my, input logic [15:0] mx);
        return {4'b0, mx, my, ox, oy, lx, ly, score, col, row};
    endfunction

    task automatic send_item(input logic cmd, input logic [IN_DATA_W-1:0] d);
        int  gap;
        bit  ok;
        gap = draw_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= cmd;
        s_axis_tdata <= d;
        do begin
            @(negedge i_clk);
            ok = s_axis_tready;
            @(posedge i_clk);
        end while (!ok);
        items_sent++;
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        bit ok;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do begin
            @(negedge i_clk);
            ok = o_cfg_ready;
            @(posedge i_clk);
        end while (!ok);
        i_cfg_valid <= 1'b0;
        if (idx == REG_SCORE_THRESHOLD) cur_thr = val;
    endtask

    task automatic setup_regs(input logic [15:0] thr, input logic [12:0] fw,
                              input logic [12:0] fh, input logic [14:0] sx,
                              input logic [14:0] sy);
        write_reg(REG_SCORE_THRESHOLD, thr);
        write_reg(REG_FRAME_WIDTH, {3'b0, fw});
        write_reg(REG_FRAME_HEIGHT, {3'b0, fh});
        write_reg(REG_SCALE_BACK_X, {1'b0, sx});
        write_reg(REG_SCALE_BACK_Y, {1'b0, sy});
    endtask

    function automatic logic [15:0] log_val();
        if ($urandom_range(0, 7) == 0) return 16'($urandom);
        return 16'($signed($urandom_range(0, 24576)) - 12288);
    endfunction

    function automatic logic [IN_DATA_W-1:0] rand_cell(input logic [15:0] score);
        return pack_item(10'($urandom), 10'($urandom), score, log_val(), log_val(),
                         16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    endfunction

    function automatic logic [15:0] pass_score();
        return 16'($urandom_range(cur_thr, 65535));
    endfunction

    task automatic random_part(input int count);
        int n, k, marks;
        n = 0;
        while (n < count) begin
            if (n % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
            k = $urandom_range(0, 9);
            if (k < 7) begin
                send_item(CMD_CELL, rand_cell(pass_score()));
                marks = (k == 0) ? $urandom_range(0, 4) : NUM_KEYPOINTS;
                repeat (marks) send_item(CMD_MARK, rand_cell(16'($urandom)));
                n += 1 + marks;
            end else if (k < 9 && cur_thr > 0) begin
                send_item(CMD_CELL, rand_cell(16'($urandom_range(0, cur_thr - 1))));
                n++;
            end else begin
                send_item(1'($urandom_range(0, 1)), rand_cell(16'($urandom)));
                n++;
            end
        end
    endtask

    initial begin
        m_axis_tready = 1'b0;
        @(posedge i_clk);
        forever begin
            int  stall;
            bit  ok;
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end
            stall = draw_gap();
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do begin
                @(negedge i_clk);
                ok = m_axis_tvalid;
                @(posedge i_clk);
            end while (!ok);
        end
    end

    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        items_sent = 0;
        no_idle = 1'b0;
        hold_req = 1'b0;
        cur_thr = 16'd32768;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes at reset settings
        send_item(CMD_MARK, pack_item('0, '0, '0, '0, '0, '0, '0, 16'h7FFF, 16'h8000));
        send_item(CMD_CELL, pack_item(10'd1023, '0, 16'hFFFF, 16'h7FFF, 16'h8000,
                                      16'h8000, 16'h7FFF, '0, '0));
        send_item(CMD_MARK, pack_item('0, '0, '0, '0, '0, '0, '0, 16'h7FFF, 16'h7FFF));
        send_item(CMD_MARK, pack_item('0, '0, '0, '0, '0, '0, '0, 16'h8000, 16'h8000));
        send_item(CMD_MARK, pack_item(10'h3FF, 10'h3FF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                      16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        send_item(CMD_MARK, pack_item('0, '0, '0, '0, '0, '0, '0, 16'h1000, 16'h1000));
        send_item(CMD_MARK, pack_item('0, '0, '0, '0, '0, '0, '0, '0, '0));
        send_item(CMD_MARK, pack_item('0, '0, '0, '0, '0, '0, '0, 16'h1000, 16'h1000));
        send_item(CMD_CELL, pack_item('0, 10'd1023, 16'd32768, 16'h8000, 16'h7FFF,
                                      16'h7FFF, 16'h8000, '0, '0));
        send_item(CMD_MARK, pack_item('0, '0, '0, '0, '0, '0, '0, 16'h0800, 16'h0800));
        send_item(CMD_CELL, pack_item(10'd5, 10'd5, 16'd32767, '0, '0, '0, '0, '0, '0));
        send_item(CMD_MARK, pack_item('0, '0, '0, '0, '0, '0, '0, 16'h0800, 16'h0800));
        send_item(CMD_CELL, pack_item(10'd60, 10'd80, 16'd40000, 16'h2000, 16'h2000,
                                      '0, '0, '0, '0));
        send_item(CMD_CELL, pack_item(10'd200, 10'd300, 16'd50000, 16'h4000, 16'h4000,
                                      16'h0800, 16'hF800, '0, '0));
        repeat (5) send_item(CMD_MARK, rand_cell(16'($urandom)));
        wait_idle();

        // small frame, low threshold, widest scale
        setup_regs(16'd0, 13'd32, 13'd32, 15'd32767, 15'd32767);
        write_reg(REG_SPARE, 16'hFFFF);
        send_item(CMD_CELL, pack_item(10'd1023, 10'd1023, '0, 16'h7FFF, 16'h7FFF,
                                      16'h7FFF, 16'h7FFF, '0, '0));
        repeat (5) send_item(CMD_MARK, pack_item('0, '0, '0, '0, '0, '0, '0,
                                                 16'h7FFF, 16'h8000));
        random_part(120);
        wait_idle();

        setup_regs(16'hFFFF, 13'd4096, 13'd4096, 15'd16384, 15'd16384);
        send_item(CMD_CELL, pack_item('0, '0, 16'hFFFE, '0, '0, '0, '0, '0, '0));
        random_part(100);
        wait_idle();

        for (int ph = 0; ph < 7; ph++) begin
            setup_regs(16'($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 49152)),
                       ($urandom_range(0, 7) == 0) ? 13'($urandom)
                                                   : 13'($urandom_range(1, 128) * 32),
                       ($urandom_range(0, 7) == 0) ? 13'($urandom)
                                                   : 13'($urandom_range(1, 128) * 32),
                       15'($urandom_range(16384, 32767)),
                       ($urandom_range(0, 7) == 0) ? 15'($urandom)
                                                   : 15'($urandom_range(16384, 32767)));
            if (ph == 2) hold_req = 1'b1;
            random_part(65);
            if (ph == 4) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
                while (pending != 0) @(posedge i_clk);
            end
            random_part(65);
            wait_idle();
        end

        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("sent %0d input items, %0d faces decoded, %0d result items compared",
                 items_sent, faces, checked);
        $display("covered reset and random register settings, full and small frames");
        if (errors == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
